@@ rtl/psve_pkg.sv @@
package psve_pkg;

  // Voice set
  localparam int VOICE_COUNT = 8;
  localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  // Field and datapath widths
  localparam int NOTE_W    = 7;
  localparam int OP_W      = 2;
  localparam int SAMPLE_W  = 28;
  localparam int OUT_IDX_W = 3;
  localparam int OUTC_W    = 3;
  localparam int AMP_W     = 25;
  localparam int PHASE_W   = 32;
  localparam int Q16_W     = 17;
  localparam int PPH_W     = 34;
  localparam int FREQ_W    = 30;
  localparam int MUL_A_W   = 31;
  localparam int MUL_B_W   = 18;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = SAMPLE_W + VIDX_W;

  // Amplitude thresholds, Q1.24
  localparam logic [AMP_W-1:0] AMP_ONE      = AMP_W'(16777216);
  localparam logic [AMP_W-1:0] SILENT_BELOW = AMP_W'(168);
  localparam logic [AMP_W-1:0] AUDIBLE_OVER = AMP_W'(16);
  localparam logic [Q16_W-1:0] Q16_ONE      = Q16_W'(65536);

  // Opcodes
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_ON   = 2'd1;
  localparam logic [OP_W-1:0] OP_OFF  = 2'd2;

  // Outcome codes
  localparam logic [OUTC_W-1:0] OUTC_REUSE    = 3'd0;
  localparam logic [OUTC_W-1:0] OUTC_FREE     = 3'd1;
  localparam logic [OUTC_W-1:0] OUTC_STOLEN   = 3'd2;
  localparam logic [OUTC_W-1:0] OUTC_RELEASED = 3'd3;
  localparam logic [OUTC_W-1:0] OUTC_NO_MATCH = 3'd4;
  localparam logic [OUTC_W-1:0] OUTC_TICK     = 3'd5;

  // Register indexes
  localparam logic [1:0] REG_SLEW = 2'd0;
  localparam logic [1:0] REG_GAIN = 2'd1;
  localparam logic [1:0] REG_PPH  = 2'd2;

  // Configuration as seen by the core, gain and slew already clamped
  typedef struct packed {
    logic [Q16_W-1:0] slew;
    logic [Q16_W-1:0] gain;
    logic [PPH_W-1:0] pph;
  } cfg_t;

  // One result transaction
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [OUT_IDX_W-1:0]       voice_index;
    logic [OUTC_W-1:0]          outcome;
  } res_t;

  // Frequencies of notes 0..11 in Q24 Hz
  function automatic logic [27:0] semi_base(input logic [3:0] s);
    logic [27:0] b;
    unique case (s)
      4'd0:    b = 28'd137167144;
      4'd1:    b = 28'd145323527;
      4'd2:    b = 28'd153964914;
      4'd3:    b = 28'd163120144;
      4'd4:    b = 28'd172819773;
      4'd5:    b = 28'd183096171;
      4'd6:    b = 28'd193983636;
      4'd7:    b = 28'd205518503;
      4'd8:    b = 28'd217739269;
      4'd9:    b = 28'd230686720;
      4'd10:   b = 28'd244404066;
      4'd11:   b = 28'd258937088;
      default: b = '0;
    endcase
    return b;
  endfunction

  // Note frequency in Q16 Hz: octave by compares, semitone by subtract
  function automatic logic [FREQ_W-1:0] note_freq(input logic [NOTE_W-1:0] n);
    logic [3:0]        oct;
    logic [NOTE_W-1:0] semi;
    logic [39:0]       f;
    oct = '0;
    for (int k = 1; k <= 10; k++) begin
      if (n >= NOTE_W'(12 * k)) oct = oct + 4'd1;
    end
    semi = n - NOTE_W'(oct) * NOTE_W'(12);
    f = (40'(semi_base(semi[3:0])) << oct) + 40'd128;
    return f[FREQ_W+7:8];
  endfunction

endpackage

@@ rtl/psve_cfg.sv @@
module psve_cfg
  import psve_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [Q16_W-1:0] slew_r;
  logic [Q16_W-1:0] gain_r;
  logic [PPH_W-1:0] pph_r;
  logic             wr_en;
  logic [1:0]       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel & penable & pwrite & pready;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slew_r <= Q16_W'(66);
      gain_r <= Q16_ONE;
      pph_r  <= PPH_W'(64'd6382652533);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SLEW: slew_r <= pwdata[Q16_W-1:0];
        REG_GAIN: gain_r <= pwdata[Q16_W-1:0];
        REG_PPH:  pph_r  <= pwdata[PPH_W-1:0];
        default:  ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_SLEW: prdata = 64'(slew_r);
      REG_GAIN: prdata = 64'(gain_r);
      REG_PPH:  prdata = 64'(pph_r);
      default:  prdata = '0;
    endcase
  end

  // Clamp Q1.16 factors to 1.0
  assign cfg.slew = (slew_r > Q16_ONE) ? Q16_ONE : slew_r;
  assign cfg.gain = (gain_r > Q16_ONE) ? Q16_ONE : gain_r;
  assign cfg.pph  = pph_r;

endmodule

@@ rtl/psve_mul.sv @@
module psve_mul
  import psve_pkg::*;
(
  input  logic                       clk,
  input  logic signed [MUL_A_W-1:0]  a,
  input  logic signed [MUL_B_W-1:0]  b,
  output logic signed [MUL_P_W-1:0]  p_r
);

  // Shared signed multiplier, product registered
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

@@ rtl/psve_core.sv @@
module psve_core
  import psve_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic [OP_W-1:0]           item_op,
  input  logic [NOTE_W-1:0]         item_note,
  input  cfg_t                      cfg,
  output logic signed [MUL_A_W-1:0] mul_a,
  output logic signed [MUL_B_W-1:0] mul_b,
  input  logic signed [MUL_P_W-1:0] mul_p,
  input  logic                      res_ready,
  output logic                      res_valid,
  output res_t                      res
);

  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_SCAN       = 4'd1;
  localparam logic [3:0] ST_MUL_LO     = 4'd2;
  localparam logic [3:0] ST_MUL_HI     = 4'd3;
  localparam logic [3:0] ST_ON_COMMIT  = 4'd4;
  localparam logic [3:0] ST_OFF_COMMIT = 4'd5;
  localparam logic [3:0] ST_TICK_A     = 4'd6;
  localparam logic [3:0] ST_TICK_B     = 4'd7;
  localparam logic [3:0] ST_TICK_C     = 4'd8;
  localparam logic [3:0] ST_TICK_SUM   = 4'd9;
  localparam logic [3:0] ST_FINISH     = 4'd10;

  localparam logic [VIDX_W-1:0] LAST_V = VIDX_W'(VOICE_COUNT - 1);
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(134217727);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(-134217728);

  // Voice file
  logic [VOICE_COUNT-1:0] act_r;
  logic [VOICE_COUNT-1:0] tgt_r;
  logic [VOICE_COUNT-1:0] nval_r;
  logic [NOTE_W-1:0]      vnote_r  [VOICE_COUNT];
  logic [PHASE_W-1:0]     phase_r  [VOICE_COUNT];
  logic [PHASE_W-1:0]     inc_r    [VOICE_COUNT];
  logic [AMP_W-1:0]       amp_r    [VOICE_COUNT];

  // Sequencer and item registers
  logic [3:0]             state_r;
  logic [VIDX_W-1:0]      vidx_r;
  logic [OP_W-1:0]        op_r;
  logic [NOTE_W-1:0]      note_r;
  logic [FREQ_W-1:0]      freq_r;
  logic                   match_hit_r;
  logic [VIDX_W-1:0]      match_idx_r;
  logic                   free_hit_r;
  logic [VIDX_W-1:0]      free_idx_r;
  logic [VIDX_W-1:0]      min_idx_r;
  logic [AMP_W-1:0]       min_amp_r;
  logic [MUL_P_W-3:0]     lo_r;
  logic                   mix_en_r;
  logic                   neg_r;
  logic [AMP_W-1:0]       newamp_r;
  logic signed [ACC_W-1:0] acc_r;
  res_t                   res_r;

  // Combinational datapath
  logic [AMP_W-1:0]        cur_amp;
  logic                    cur_free;
  logic                    cur_match;
  logic signed [AMP_W:0]   diff;
  logic signed [32:0]      step;
  logic [32:0]             amp_sum;
  logic [AMP_W-1:0]        amp_new;
  logic                    free_new;
  logic                    mix_now;
  logic [25:0]             term;
  logic signed [ACC_W-1:0] acc_add;
  logic signed [ACC_W-1:0] acc_sat;
  logic [63:0]             inc_sum;
  logic [VIDX_W-1:0]       sel_idx;
  logic [OUTC_W-1:0]       sel_outc;
  logic                    accept;

  assign item_ready = (state_r == ST_IDLE);
  assign accept     = item_valid & item_ready;
  assign res_valid  = (state_r == ST_FINISH) & res_ready;
  assign res        = res_r;

  // Current voice under the walk
  assign cur_amp   = amp_r[vidx_r];
  assign cur_free  = !act_r[vidx_r] && !tgt_r[vidx_r] && (cur_amp < SILENT_BELOW);
  assign cur_match = nval_r[vidx_r] && (vnote_r[vidx_r] == note_r);

  // Slew: distance to goal, then add floor of the scaled product
  assign diff     = $signed({1'b0, (tgt_r[vidx_r] ? AMP_ONE : {AMP_W{1'b0}})})
                  - $signed({1'b0, cur_amp});
  assign step     = mul_p[MUL_P_W-1:16];
  assign amp_sum  = {{(33-AMP_W){1'b0}}, cur_amp} + step;
  assign amp_new  = amp_sum[AMP_W-1:0];
  assign free_new = !act_r[vidx_r] && !tgt_r[vidx_r] && (amp_new < SILENT_BELOW);
  assign mix_now  = !free_new && (act_r[vidx_r] || (amp_new > AUDIBLE_OVER));

  // Mix: signed add of the scaled amplitude, then clamp
  assign term    = mul_p[41:16];
  assign acc_add = !mix_en_r ? acc_r :
                   neg_r ? acc_r - $signed({{(ACC_W-26){1'b0}}, term})
                         : acc_r + $signed({{(ACC_W-26){1'b0}}, term});
  assign acc_sat = (acc_add > ACC_MAX) ? ACC_MAX :
                   (acc_add < ACC_MIN) ? ACC_MIN : acc_add;

  // Increment: high partial product joined with the low one
  assign inc_sum = {mul_p[MUL_P_W-3:0], 17'b0} + {17'b0, lo_r};

  // Voice choice for note on
  always_comb begin
    priority if (match_hit_r) begin
      sel_idx  = match_idx_r;
      sel_outc = OUTC_REUSE;
    end else if (free_hit_r) begin
      sel_idx  = free_idx_r;
      sel_outc = OUTC_FREE;
    end else begin
      sel_idx  = min_idx_r;
      sel_outc = OUTC_STOLEN;
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    unique case (state_r)
      ST_TICK_A: begin
        mul_a = MUL_A_W'(diff);
        mul_b = $signed({1'b0, cfg.slew});
      end
      ST_TICK_C: begin
        mul_a = $signed({{(MUL_A_W-AMP_W){1'b0}}, newamp_r});
        mul_b = $signed({1'b0, cfg.gain});
      end
      ST_MUL_LO: begin
        mul_a = $signed({1'b0, freq_r});
        mul_b = $signed({1'b0, cfg.pph[16:0]});
      end
      default: begin
        mul_a = $signed({1'b0, freq_r});
        mul_b = $signed({1'b0, cfg.pph[PPH_W-1:17]});
      end
    endcase
  end

  // Sequencer and voice file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vidx_r      <= '0;
      mix_en_r    <= 1'b0;
      match_hit_r <= 1'b0;
      free_hit_r  <= 1'b0;
      act_r       <= '0;
      tgt_r       <= '0;
      nval_r      <= '0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        vnote_r[v] <= '0;
        phase_r[v] <= '0;
        inc_r[v]   <= '0;
        amp_r[v]   <= '0;
      end
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            vidx_r      <= '0;
            mix_en_r    <= 1'b0;
            match_hit_r <= 1'b0;
            free_hit_r  <= 1'b0;
            unique case (item_op)
              OP_TICK:       state_r <= ST_TICK_A;
              OP_ON, OP_OFF: state_r <= ST_SCAN;
              default:       state_r <= ST_IDLE;
            endcase
          end
        end
        ST_SCAN: begin
          if (!match_hit_r && cur_match) match_hit_r <= 1'b1;
          if (!free_hit_r && cur_free) free_hit_r <= 1'b1;
          if (vidx_r == LAST_V) begin
            vidx_r  <= '0;
            state_r <= (op_r == OP_ON) ? ST_MUL_LO : ST_OFF_COMMIT;
          end else begin
            vidx_r <= vidx_r + 1'b1;
          end
        end
        ST_MUL_LO: state_r <= ST_MUL_HI;
        ST_MUL_HI: state_r <= ST_ON_COMMIT;
        ST_ON_COMMIT: begin
          act_r[sel_idx]   <= 1'b1;
          tgt_r[sel_idx]   <= 1'b1;
          nval_r[sel_idx]  <= 1'b1;
          vnote_r[sel_idx] <= note_r;
          inc_r[sel_idx]   <= inc_sum[63:32];
          phase_r[sel_idx] <= '0;
          state_r          <= ST_FINISH;
        end
        ST_OFF_COMMIT: begin
          if (match_hit_r) begin
            act_r[match_idx_r] <= 1'b0;
            tgt_r[match_idx_r] <= 1'b0;
          end
          state_r <= ST_FINISH;
        end
        ST_TICK_A: begin
          mix_en_r <= 1'b0;
          state_r  <= ST_TICK_B;
        end
        ST_TICK_B: begin
          mix_en_r <= mix_now;
          if (free_new) begin
            nval_r[vidx_r]  <= 1'b0;
            vnote_r[vidx_r] <= '0;
            amp_r[vidx_r]   <= '0;
            phase_r[vidx_r] <= '0;
            inc_r[vidx_r]   <= '0;
          end else begin
            amp_r[vidx_r] <= amp_new;
            if (mix_now) phase_r[vidx_r] <= phase_r[vidx_r] + inc_r[vidx_r];
          end
          state_r <= ST_TICK_C;
        end
        ST_TICK_C: begin
          if (vidx_r == LAST_V) begin
            vidx_r  <= '0;
            state_r <= ST_TICK_SUM;
          end else begin
            vidx_r  <= vidx_r + 1'b1;
            state_r <= ST_TICK_A;
          end
        end
        ST_TICK_SUM: state_r <= ST_FINISH;
        ST_FINISH: begin
          if (res_ready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Item, scan, product and result payload
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_r   <= item_op;
          note_r <= item_note;
          freq_r <= note_freq(item_note);
          acc_r  <= '0;
        end
      end
      ST_SCAN: begin
        if (!match_hit_r && cur_match) match_idx_r <= vidx_r;
        if (!free_hit_r && cur_free) free_idx_r <= vidx_r;
        if (vidx_r == '0 || cur_amp < min_amp_r) begin
          min_idx_r <= vidx_r;
          min_amp_r <= cur_amp;
        end
      end
      ST_MUL_HI: lo_r <= mul_p[MUL_P_W-3:0];
      ST_ON_COMMIT: begin
        res_r.sample      <= '0;
        res_r.voice_index <= OUT_IDX_W'(sel_idx);
        res_r.outcome     <= sel_outc;
      end
      ST_OFF_COMMIT: begin
        res_r.sample      <= '0;
        res_r.voice_index <= match_hit_r ? OUT_IDX_W'(match_idx_r) : '0;
        res_r.outcome     <= match_hit_r ? OUTC_RELEASED : OUTC_NO_MATCH;
      end
      ST_TICK_A: acc_r <= acc_add;
      ST_TICK_B: begin
        newamp_r <= amp_new;
        neg_r    <= phase_r[vidx_r][PHASE_W-1];
      end
      ST_TICK_SUM: begin
        res_r.sample      <= acc_sat[SAMPLE_W-1:0];
        res_r.voice_index <= '0;
        res_r.outcome     <= OUTC_TICK;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/polyphonic_square_voice_engine_top.sv @@
// Square-wave voice engine with eight voices.
// Input stream: in_tuser carries the opcode (sample tick, note on, note
// off), in_tdata the MIDI note. Each accepted transaction gives exactly one
// result transaction on the output stream, except the unused opcode three,
// which is dropped. The result carries the mixed sample and voice index in
// out_tdata and the outcome code in out_tuser.
// Per voice, a tick steps through the slew product, the amplitude update
// and the mix product, all through one shared multiplier; note items walk
// the voices once to find a match, a free voice and the quietest voice.
// in_tready is high only between items, so a new item is taken only once
// the core has handed the result of the last one to the output register.
// An output register holds the result: a new item is taken while it waits,
// and the core holds its next result until the receiver takes the previous.
// Reset (rst_n low, synchronous) silences every voice, frees every note and
// loads the register defaults. Registers sit on the APB port at byte
// addresses 0, 8, 16; the user must write them only while no item is in
// flight, as the block itself does not enforce it.
module polyphonic_square_voice_engine_top
  import psve_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [6:0] note, [7] zero
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [27:0] sample, [30:28] voice_index, [31] zero
  output logic [2:0]  out_tuser,  // [2:0] outcome
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  cfg_t                      cfg;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic                      res_ready;
  logic                      res_valid;
  res_t                      res;
  logic                      out_valid_r;
  res_t                      out_r;

  psve_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  psve_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  psve_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item_op    (in_tuser),
    .item_note  (in_tdata[NOTE_W-1:0]),
    .cfg        (cfg),
    .mul_a      (mul_a),
    .mul_b      (mul_b),
    .mul_p      (mul_p),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Output slot is free when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_tready;

  // Output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload, hold while stalled
  always_ff @(posedge clk) begin
    if (res_valid) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.voice_index, out_r.sample};
  assign out_tuser  = out_r.outcome;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import psve_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_OFF_CYCLES = 800;
  localparam int PHASE_COUNT     = 6;
  localparam int ITEMS_PER_PHASE = 272;
  localparam int MAX_REPORTS     = 10;
  localparam longint SAMPLE_HI   = 64'sd134217727;
  localparam longint SAMPLE_LO   = -64'sd134217728;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // One row of the directed script: an item, or a register write
  typedef struct packed {
    row_kind_t        kind;
    logic [OP_W-1:0]  op;
    logic [NOTE_W-1:0] note;
    logic             typed;
    res_t             want;
    logic [1:0]       reg_idx;
    logic [63:0]      reg_val;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [6:0] note, [7] zero
  logic [1:0]  in_tuser = '0;   // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [27:0] sample, [30:28] voice_index, [31] zero
  logic [2:0]  out_tuser;       // [2:0] outcome
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  polyphonic_square_voice_engine_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Voice state and register shadows of the engine
  bit                v_on   [VOICE_COUNT];
  bit [NOTE_W-1:0]   v_note [VOICE_COUNT];
  bit                v_held [VOICE_COUNT];
  bit [PHASE_W-1:0]  v_phase[VOICE_COUNT];
  bit [PHASE_W-1:0]  v_inc  [VOICE_COUNT];
  bit [AMP_W-1:0]    v_amp  [VOICE_COUNT];
  bit                v_aim  [VOICE_COUNT];
  bit [Q16_W-1:0]    slew_reg = 17'd66;
  bit [Q16_W-1:0]    gain_reg = 17'd65536;
  bit [PPH_W-1:0]    pph_reg  = 34'd6382652533;

  // Frequencies of the twelve semitones of the lowest octave, Q24 Hz
  bit [27:0] semitone_q24 [12] = '{
    28'd137167144, 28'd145323527, 28'd153964914, 28'd163120144,
    28'd172819773, 28'd183096171, 28'd193983636, 28'd205518503,
    28'd217739269, 28'd230686720, 28'd244404066, 28'd258937088
  };

  res_t due_results[$];
  int   mismatch_count = 0;
  int   burst_left = 0;
  bit   hold_off_req = 1'b0;
  bit   hold_off_done = 1'b0;

  function automatic bit [Q16_W-1:0] clamp_unit(input bit [Q16_W-1:0] x);
    return (x > Q16_ONE) ? Q16_ONE : x;
  endfunction

  function automatic bit [PHASE_W-1:0] phase_step(input bit [NOTE_W-1:0] n);
    bit [63:0] freq;
    freq = 64'(semitone_q24[n % 12]) << (n / 12);
    freq = (freq + 64'd128) >> 8;
    return PHASE_W'((freq * 64'(pph_reg)) >> 32);
  endfunction

  function automatic bit voice_idle(input int v);
    return !v_on[v] && !v_aim[v] && (v_amp[v] < SILENT_BELOW);
  endfunction

  // Apply one item to the voice set; returns 0 when the item gives no result
  function automatic bit engine_step(input logic [OP_W-1:0] op, input logic [NOTE_W-1:0] n,
                                     output res_t r);
    longint acc, goal, diff, prod, stride, term;
    bit [Q16_W-1:0] g, s;
    int v, k;
    r = '0;
    v = -1;
    acc = 0;
    g = clamp_unit(gain_reg);
    s = clamp_unit(slew_reg);
    case (op)
      OP_TICK: begin
        for (k = 0; k < VOICE_COUNT; k++) begin
          // slew toward the target, rounding down
          goal = v_aim[k] ? longint'(AMP_ONE) : 64'sd0;
          diff = goal - longint'(v_amp[k]);
          prod = diff * longint'(s);
          stride = (prod >= 0) ? prod / 65536 : -((-prod + 65535) / 65536);
          v_amp[k] = AMP_W'(longint'(v_amp[k]) + stride);
          if (voice_idle(k)) begin
            v_held[k] = 1'b0;
            v_note[k] = '0;
            v_amp[k] = '0;
            v_phase[k] = '0;
            v_inc[k] = '0;
          end else if (v_on[k] || v_amp[k] > AUDIBLE_OVER) begin
            term = longint'((64'(v_amp[k]) * 64'(g)) >> 16);
            acc += v_phase[k][PHASE_W-1] ? -term : term;
            v_phase[k] = v_phase[k] + v_inc[k];
          end
        end
        if (acc > SAMPLE_HI) acc = SAMPLE_HI;
        if (acc < SAMPLE_LO) acc = SAMPLE_LO;
        r.sample = SAMPLE_W'(acc);
        r.outcome = OUTC_TICK;
        return 1'b1;
      end
      OP_ON: begin
        r.outcome = OUTC_REUSE;
        for (k = 0; k < VOICE_COUNT; k++)
          if (v < 0 && v_held[k] && v_note[k] == n) v = k;
        if (v < 0) begin
          r.outcome = OUTC_FREE;
          for (k = 0; k < VOICE_COUNT; k++)
            if (v < 0 && voice_idle(k)) v = k;
        end
        if (v < 0) begin
          // steal the quietest voice, lowest index on a tie
          r.outcome = OUTC_STOLEN;
          v = 0;
          for (k = 1; k < VOICE_COUNT; k++)
            if (v_amp[k] < v_amp[v]) v = k;
        end
        v_on[v] = 1'b1;
        v_note[v] = n;
        v_held[v] = 1'b1;
        v_aim[v] = 1'b1;
        v_inc[v] = phase_step(n);
        v_phase[v] = '0;
        r.voice_index = OUT_IDX_W'(v);
        return 1'b1;
      end
      OP_OFF: begin
        for (k = 0; k < VOICE_COUNT; k++)
          if (v < 0 && v_held[k] && v_note[k] == n) v = k;
        if (v >= 0) begin
          v_on[v] = 1'b0;
          v_aim[v] = 1'b0;
          r.voice_index = OUT_IDX_W'(v);
          r.outcome = OUTC_RELEASED;
        end else begin
          r.outcome = OUTC_NO_MATCH;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic row_t item_row(input logic [OP_W-1:0] op, input logic [NOTE_W-1:0] n);
    row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.op = op;
    row.note = n;
    return row;
  endfunction

  function automatic row_t known_row(input logic [OP_W-1:0] op, input logic [NOTE_W-1:0] n,
                                     input logic [SAMPLE_W-1:0] smp,
                                     input logic [OUT_IDX_W-1:0] vi,
                                     input logic [OUTC_W-1:0] oc);
    row_t row;
    row = item_row(op, n);
    row.typed = 1'b1;
    row.want.sample = smp;
    row.want.voice_index = vi;
    row.want.outcome = oc;
    return row;
  endfunction

  function automatic row_t reg_row(input logic [1:0] idx, input logic [63:0] val);
    row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Offer one transaction, honoring the burst/gap pattern, and log its result
  task automatic offer(input logic [OP_W-1:0] op, input logic [NOTE_W-1:0] n,
                       input bit typed, input res_t want);
    int gap;
    res_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(40, 1);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {1'b0, n};
    do @(posedge clk); while (!in_tready);
    if (engine_step(op, n, r)) begin
      if (typed) r = want;
      due_results = {due_results, r};
    end
  endtask

  // Drop valid and wait until the engine has nothing in flight
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write a register, read it back, and update the shadow
  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
    logic [63:0] kept;
    case (idx)
      REG_SLEW: kept = val & 64'h1_FFFF;
      REG_GAIN: kept = val & 64'h1_FFFF;
      default:  kept = val & 64'h3_FFFF_FFFF;
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // turn the transfer around into a read of the same register
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== kept)
      flag_mismatch($sformatf("register %0d read back %0h, expected %0h", idx, prdata, kept));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SLEW: slew_reg = kept[Q16_W-1:0];
      REG_GAIN: gain_reg = kept[Q16_W-1:0];
      default:  pph_reg = kept[PPH_W-1:0];
    endcase
  endtask

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin : result_check
    res_t got, want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got.sample = out_tdata[SAMPLE_W-1:0];
      got.voice_index = out_tdata[SAMPLE_W+OUT_IDX_W-1:SAMPLE_W];
      got.outcome = out_tuser;
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result sample %0d idx %0d outcome %0d",
                                got.sample, got.voice_index, got.outcome));
      end else begin
        want = due_results.pop_front();
        if (got.sample !== want.sample || got.voice_index !== want.voice_index ||
            got.outcome !== want.outcome)
          flag_mismatch($sformatf(
            "expected sample %0d idx %0d outcome %0d, got sample %0d idx %0d outcome %0d",
            want.sample, want.voice_index, want.outcome,
            got.sample, got.voice_index, got.outcome));
      end
    end
  end

  // Receiver: stretches of random ready patterns, plus one long hold-off
  initial begin : sink
    int mode, stretch;
    mode = 0;
    stretch = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end
      if (stretch == 0) begin
        mode = $urandom_range(3, 0);
        stretch = $urandom_range(256, 16);
      end
      stretch--;
      case (mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(1, 0));
        2:       out_tready <= ($urandom_range(3, 0) == 0);
        default: out_tready <= ((stretch % 6) < 4);
      endcase
    end
  end

  initial begin
    #20_000_000;
    $display("** polyphonic_square_voice_engine_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    row_t script[$];
    logic [NOTE_W-1:0] note_pool [12];
    logic [63:0] slew_v, gain_v, pph_v;
    logic [OP_W-1:0] op;
    logic [NOTE_W-1:0] n;
    int pick, sent;

    // directed script: reset state, allocation order, saturation, clamps
    script = {script, known_row(OP_TICK, 7'd127, '0, '0, OUTC_TICK)};
    script = {script, known_row(OP_OFF, 7'd60, '0, '0, OUTC_NO_MATCH)};
    script = {script, reg_row(REG_SLEW, 64'd131071)};
    script = {script, known_row(OP_ON, 7'd0, '0, 3'd0, OUTC_FREE)};
    script = {script, known_row(OP_ON, 7'd127, '0, 3'd1, OUTC_FREE)};
    script = {script, known_row(OP_ON, 7'd0, '0, 3'd0, OUTC_REUSE)};
    for (int k = 0; k < 6; k++)
      script = {script, known_row(OP_ON, 7'(60 + k), '0, 3'(2 + k), OUTC_FREE)};
    // all eight voices at full scale, in phase: clips at the positive rail
    script = {script, known_row(OP_TICK, 7'd0, 28'h7FF_FFFF, '0, OUTC_TICK)};
    script = {script, known_row(OP_ON, 7'd70, '0, 3'd0, OUTC_STOLEN)};
    script = {script, item_row(OP_TICK, 7'd0)};
    script = {script, known_row(OP_OFF, 7'd127, '0, 3'd1, OUTC_RELEASED)};
    script = {script, item_row(OP_TICK, 7'd0)};
    script = {script, known_row(OP_OFF, 7'd127, '0, '0, OUTC_NO_MATCH)};
    script = {script, known_row(OP_ON, 7'd100, '0, 3'd1, OUTC_FREE)};
    script = {script, item_row(OP_UNUSED, 7'd127)};
    script = {script, reg_row(REG_GAIN, 64'd0)};
    script = {script, known_row(OP_TICK, 7'd0, '0, '0, OUTC_TICK)};
    script = {script, reg_row(REG_GAIN, 64'd131071)};
    script = {script, reg_row(REG_SLEW, 64'd0)};
    script = {script, item_row(OP_TICK, 7'd0)};
    script = {script, known_row(OP_OFF, 7'd60, '0, 3'd2, OUTC_RELEASED)};
    script = {script, known_row(OP_OFF, 7'd63, '0, 3'd5, OUTC_RELEASED)};
    script = {script, item_row(OP_TICK, 7'd0)};

    // hold reset
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        settle();
        cfg_write(script[i].reg_idx, script[i].reg_val);
      end else begin
        offer(script[i].op, script[i].note, script[i].typed, script[i].want);
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin
          slew_v = 64'd66;
          gain_v = 64'd65536;
          pph_v = 64'd6382652533;
        end
        1: begin
          slew_v = 64'd65536;
          gain_v = 64'd32768;
          pph_v = 64'd1466015503;
        end
        2: begin
          slew_v = 64'($urandom_range(20000, 500));
          gain_v = 64'($urandom_range(65536, 0));
          pph_v = 64'd8796093022;
        end
        3: begin
          slew_v = 64'd1;
          gain_v = 64'd65536;
          pph_v = 64'h3_FFFF_FFFF;
        end
        4: begin
          slew_v = 64'd131071;
          gain_v = 64'd131071;
          pph_v = {$urandom_range(3, 0), $urandom()};
        end
        default: begin
          // random values with junk above the register widths
          slew_v = {$urandom(), $urandom()};
          gain_v = {$urandom(), $urandom()};
          pph_v = {$urandom(), $urandom()};
        end
      endcase
      settle();
      cfg_write(REG_SLEW, slew_v);
      cfg_write(REG_GAIN, gain_v);
      cfg_write(REG_PPH, pph_v);
      foreach (note_pool[i]) note_pool[i] = 7'($urandom_range(127, 0));
      if (ph == 1) hold_off_req = 1'b1;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99, 0);
        op = (pick < 42) ? OP_TICK : (pick < 70) ? OP_ON : (pick < 92) ? OP_OFF : OP_UNUSED;
        n = ($urandom_range(99, 0) < 85) ? note_pool[$urandom_range(11, 0)]
                                         : 7'($urandom_range(127, 0));
        offer(op, n, 1'b0, '0);
        if (op != OP_UNUSED) sent++;
      end
    end

    settle();
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("** polyphonic_square_voice_engine_top: PASSED **");
    end else begin
      $display("** polyphonic_square_voice_engine_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/psve_pkg.sv
rtl/psve_cfg.sv
rtl/psve_mul.sv
rtl/psve_core.sv
rtl/polyphonic_square_voice_engine_top.sv
bench/tb.sv
